FILE: hdl/uesc_pkg.sv
package uesc_pkg;

	typedef enum logic [1:0] {
		MODE_PLAIN = 2'd0,
		MODE_SLASH = 2'd1,
		MODE_ESC   = 2'd2
	} mode_t;

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_U         = 8'h75;
	localparam logic [7:0] UTF8_LEAD3   = 8'hE0;
	localparam logic [7:0] UTF8_CONT    = 8'h80;
	localparam logic [2:0] ESC_DIGITS   = 3'd4;

	// one input item's worth of results, bytes[0] goes out first
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      count;
		logic            bad;
		logic            last;
	} job_t;

endpackage

FILE: hdl/uesc_front.sv
module uesc_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     in_char,
	input  logic           stream_last,
	output logic           job_valid,
	output uesc_pkg::job_t job,
	input  logic           job_ready
);
	import uesc_pkg::*;

	mode_t       mode_q, mode_n;
	logic [2:0]  digits_q, digits_n;
	logic [15:0] code_q, code_n;
	logic        stopped_q, stopped_n;
	logic        any_q, any_n;
	logic        is_hex;
	logic [3:0]  hexd;
	logic        accept;

	assign in_ready = job_ready;
	assign accept   = in_valid && job_ready;

	always_comb begin
		is_hex = 1'b0;
		hexd   = 4'd0;
		if (in_char inside {[8'h30:8'h39]}) begin
			is_hex = 1'b1;
			hexd   = in_char[3:0];
		end else if (in_char inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			is_hex = 1'b1;
			hexd   = in_char[3:0] + 4'd9;
		end
	end

	always_comb begin
		mode_n    = mode_q;
		digits_n  = digits_q;
		code_n    = code_q;
		stopped_n = stopped_q;
		any_n     = any_q;
		job       = '0;
		job.last  = stream_last;
		case (mode_q)
			MODE_ESC: begin
				if (!stopped_q && is_hex) begin
					code_n = {code_q[11:0], hexd};
					any_n  = 1'b1;
				end else begin
					stopped_n = 1'b1;
				end
				digits_n = digits_q + 3'd1;
				if (digits_n >= ESC_DIGITS || stream_last) begin
					mode_n = MODE_PLAIN;
					if (!any_n) begin
						job.count = 2'd1;
						job.bad   = 1'b1;
					end else begin
						job.count    = 2'd3;
						job.bytes[0] = UTF8_LEAD3 | {4'h0, code_n[15:12]};
						job.bytes[1] = UTF8_CONT | {2'b00, code_n[11:6]};
						job.bytes[2] = UTF8_CONT | {2'b00, code_n[5:0]};
					end
				end
			end
			default: begin
				if (mode_q == MODE_SLASH && in_char == CH_U) begin
					digits_n  = 3'd0;
					code_n    = '0;
					stopped_n = 1'b0;
					any_n     = 1'b0;
					mode_n    = MODE_ESC;
					if (stream_last) begin
						mode_n    = MODE_PLAIN;
						job.count = 2'd1;
						job.bad   = 1'b1;
					end
				end else begin
					mode_n = MODE_PLAIN;
					if (mode_q == MODE_SLASH) begin
						job.bytes[0] = CH_BACKSLASH;
						job.count    = 2'd1;
					end
					if (in_char == CH_BACKSLASH && !stream_last) begin
						mode_n = MODE_SLASH;
					end else if (mode_q == MODE_SLASH) begin
						job.bytes[1] = in_char;
						job.count    = 2'd2;
					end else begin
						job.bytes[0] = in_char;
						job.count    = 2'd1;
					end
				end
			end
		endcase
		if (stream_last) begin
			mode_n    = MODE_PLAIN;
			digits_n  = 3'd0;
			code_n    = '0;
			stopped_n = 1'b0;
			any_n     = 1'b0;
		end
	end

	assign job_valid = in_valid && (job.count != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_PLAIN;
			digits_q  <= 3'd0;
			code_q    <= '0;
			stopped_q <= 1'b0;
			any_q     <= 1'b0;
		end else if (accept) begin
			mode_q    <= mode_n;
			digits_q  <= digits_n;
			code_q    <= code_n;
			stopped_q <= stopped_n;
			any_q     <= any_n;
		end
	end

	a_esc_digits: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_ESC |-> digits_q < ESC_DIGITS)
		else $error("escape digit count out of range");

	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		accept && stream_last |=> mode_q == MODE_PLAIN && digits_q == 3'd0 && !any_q)
		else $error("state not cleared after last byte");

	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && stream_last |-> job_valid)
		else $error("last byte produced no item");

endmodule

FILE: hdl/uesc_fifo.sv
module uesc_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  uesc_pkg::job_t push_job,
	output logic           pop_valid,
	input  logic           pop_ready,
	output uesc_pkg::job_t pop_job
);
	import uesc_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          push, pop;

	assign push_ready = cnt_q != CW'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_ready && pop_valid;
	assign pop_job    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: hdl/uesc_back.sv
module uesc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	output logic           job_pop,
	input  uesc_pkg::job_t job,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_byte,
	output logic           bad_escape,
	output logic           run_last,
	output logic           stream_done
);
	import uesc_pkg::*;

	logic [1:0] idx_q;
	logic       fire;

	assign out_valid   = job_valid;
	assign fire        = out_valid && out_ready;
	assign run_last    = (idx_q + 2'd1) == job.count;
	assign stream_done = run_last && job.last;
	assign bad_escape  = job.bad;
	assign job_pop     = fire && run_last;

	always_comb begin
		case (idx_q)
			2'd0:    out_byte = job.bytes[0];
			2'd1:    out_byte = job.bytes[1];
			2'd2:    out_byte = job.bytes[2];
			default: out_byte = 8'h00;
		endcase
	end

	// advance through the bytes of the head entry, restart on the next one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (fire) begin
			idx_q <= run_last ? 2'd0 : idx_q + 2'd1;
		end
	end

	a_no_empty_job: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> job.count != 2'd0)
		else $error("empty entry reached output");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> idx_q < job.count)
		else $error("byte index past entry count");

	a_bad_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_escape |-> run_last && out_byte == 8'h00)
		else $error("error item not alone or nonzero");

endmodule

FILE: hdl/unicode_escape_to_utf8.sv
// Channel  Dir  Signals                    Contents
// s_*      in   tvalid tready tdata tlast  tdata[7:0] in_char, tlast stream_last
// m_*      out  tvalid tready tdata tuser  tdata[7:0] out_byte, tlast run_last,
//               tlast                      tuser[0] bad_escape, tuser[1] stream_done
// One input byte is accepted per cycle while the queue has room.
// Each byte yields zero to three result items; the back end sends one per cycle
// while m_tready is high; the queue absorbs the three items of a decoded escape.
// Result entries are registered in the queue before they reach the output.
// Reset clears parse state, queue pointers and the byte index; no clearing pass.
// A stalled output fills the queue (QUEUE_DEPTH entries), then s_tready drops.
module unicode_escape_to_utf8 #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] in_char
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [7:0] out_byte
	output logic [1:0] m_tuser,  // [0] bad_escape, [1] stream_done
	output logic       m_tlast
);
	import uesc_pkg::*;

	job_t front_job, head_job;
	logic front_valid, front_ready;
	logic head_valid, head_pop;

	uesc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_char     (s_tdata),
		.stream_last (s_tlast),
		.job_valid   (front_valid),
		.job         (front_job),
		.job_ready   (front_ready)
	);

	uesc_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_job   (front_job),
		.pop_valid  (head_valid),
		.pop_ready  (head_pop),
		.pop_job    (head_job)
	);

	uesc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (head_valid),
		.job_pop     (head_pop),
		.job         (head_job),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_byte    (m_tdata),
		.bad_escape  (m_tuser[0]),
		.run_last    (m_tlast),
		.stream_done (m_tuser[1])
	);

endmodule
